// ===== rtl/lanc_pkg.sv =====
// ---------------------------------------------------------------------------
// lanc_pkg: shared types and constants for the Life neighbor-count block
// Field geometry, cell layout and the item structs of both channels.
// ---------------------------------------------------------------------------
package lanc_pkg;

  localparam int MaxRows    = 64;
  localparam int MaxColumns = 64;
  localparam int RowW       = $clog2(MaxRows);
  localparam int ColW       = $clog2(MaxColumns);
  localparam int AddrW      = RowW + ColW;
  localparam int Cells      = MaxRows * MaxColumns;
  localparam int SweepW     = AddrW + 1;
  localparam int SizeW      = 7;
  localparam int CellW      = 5;
  localparam int GenW       = 32;

  // Request codes. The last one has no operation behind it.
  localparam logic [1:0] REQ_SET    = 2'd0;
  localparam logic [1:0] REQ_STEP   = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic REG_ROWS    = 1'b0;
  localparam logic REG_COLUMNS = 1'b1;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [RowW-1:0] cell_row;
    logic [ColW-1:0] cell_column;
  } req_item_t;

  typedef struct packed {
    logic            cell_alive;
    logic [GenW-1:0] generation_count;
  } rsp_item_t;

endpackage

// ===== rtl/lanc_nbr.sv =====
// ---------------------------------------------------------------------------
// lanc_nbr: wrapped neighbor address
// Gives the cell address of one of the nine cells around a center cell,
// selected by a 0..8 index in row-major order, wrapping at the field edge.
// ---------------------------------------------------------------------------
module lanc_nbr
  import lanc_pkg::*;
(
  input  logic [RowW-1:0]  row,
  input  logic [ColW-1:0]  col,
  input  logic [SizeW-1:0] rows,
  input  logic [SizeW-1:0] cols,
  input  logic [3:0]       sel,
  output logic [AddrW-1:0] addr
);

  logic [1:0]       dr;
  logic [1:0]       dc;
  logic [SizeW-1:0] row_w;
  logic [SizeW-1:0] col_w;
  logic [SizeW-1:0] row_n;
  logic [SizeW-1:0] col_n;

  // Split the index into a row and a column offset.
  always_comb begin
    case (sel)
      4'd0:    begin dr = 2'd0; dc = 2'd0; end
      4'd1:    begin dr = 2'd0; dc = 2'd1; end
      4'd2:    begin dr = 2'd0; dc = 2'd2; end
      4'd3:    begin dr = 2'd1; dc = 2'd0; end
      4'd4:    begin dr = 2'd1; dc = 2'd1; end
      4'd5:    begin dr = 2'd1; dc = 2'd2; end
      4'd6:    begin dr = 2'd2; dc = 2'd0; end
      4'd7:    begin dr = 2'd2; dc = 2'd1; end
      default: begin dr = 2'd2; dc = 2'd2; end
    endcase
  end

  // Wrap the row and column around the torus.
  always_comb begin
    row_w = SizeW'(row);
    col_w = SizeW'(col);
    case (dr)
      2'd0:    row_n = (row_w == '0) ? rows - 1'b1 : row_w - 1'b1;
      2'd2:    row_n = (row_w + 1'b1 >= rows) ? '0 : row_w + 1'b1;
      default: row_n = row_w;
    endcase
    case (dc)
      2'd0:    col_n = (col_w == '0) ? cols - 1'b1 : col_w - 1'b1;
      2'd2:    col_n = (col_w + 1'b1 >= cols) ? '0 : col_w + 1'b1;
      default: col_n = col_w;
    endcase
  end

  assign addr = {row_n[RowW-1:0], col_n[ColW-1:0]};

endmodule

// ===== rtl/life_automaton_neighbor_count.sv =====
// ---------------------------------------------------------------------------
// life_automaton_neighbor_count: Life on a torus with stored neighbor counts
// Sequencer over a front and a back cell memory with one shared update path.
// ---------------------------------------------------------------------------
// Requests enter on req (req_valid/req_ready); each gives exactly one item on
// rsp (rsp_valid/rsp_ready). A set makes a cell alive and raises the counts
// of its eight wrapped neighbors; a step advances one generation; a read
// returns the alive bit. One request is handled at a time.
// A read, and a set on a live cell, only read the cell; a set on a dead
// one does nine read-modify-writes. A step reads every cell in use, does
// nine read-modify-writes per cell that changes, and then copies the back
// memory into the front memory cell by cell through the single write
// port of each memory.
// After reset a clearing pass zeroes both memories; req_ready stays low
// meanwhile. Configuration writes are taken at any time.
// The result waits in an output register while rsp_ready is low, and no new
// request is taken until it has been delivered.
// ---------------------------------------------------------------------------
module life_automaton_neighbor_count
  import lanc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_item_t        req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_item_t        rsp,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [SizeW-1:0] cfg_data
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CELL_RD  = 4'd2;
  localparam logic [3:0] S_CELL_DEC = 4'd3;
  localparam logic [3:0] S_WALK_RD  = 4'd4;
  localparam logic [3:0] S_WALK_DEC = 4'd5;
  localparam logic [3:0] S_ADJ_RD   = 4'd6;
  localparam logic [3:0] S_ADJ_WR   = 4'd7;
  localparam logic [3:0] S_COPY     = 4'd8;

  logic [3:0]       state;
  logic [SizeW-1:0] rows_cfg;
  logic [SizeW-1:0] cols_cfg;
  logic [SizeW-1:0] rows;
  logic [SizeW-1:0] cols;
  logic [SizeW-1:0] rows_clamp;
  logic [SizeW-1:0] cols_clamp;
  logic [1:0]       kind;
  logic [RowW-1:0]  row;
  logic [ColW-1:0]  col;
  logic [3:0]       sel;
  logic             adj_up;
  logic             adj_both;
  logic [SweepW-1:0] sweep;
  logic [GenW-1:0]  gen;

  logic [CellW-1:0] front_mem [Cells];
  logic [CellW-1:0] back_mem  [Cells];
  logic [CellW-1:0] front_rd;
  logic [CellW-1:0] back_rd;
  logic [AddrW-1:0] front_raddr;
  logic [AddrW-1:0] back_raddr;
  logic [AddrW-1:0] front_waddr;
  logic [AddrW-1:0] back_waddr;
  logic [CellW-1:0] front_wdata;
  logic [CellW-1:0] back_wdata;
  logic             front_we;
  logic             back_we;

  logic [AddrW-1:0] center;
  logic [AddrW-1:0] nbr_addr;
  logic [CellW-1:0] adj_val;
  logic [3:0]       cnt;
  logic             accept;
  logic             last_col;
  logic             last_row;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == S_IDLE) && !rsp_valid;
  assign center    = {row, col};

  // Size registers are used clamped to 3..maximum.
  always_comb begin
    rows_clamp = (rows_cfg < SizeW'(3)) ? SizeW'(3) :
                 (rows_cfg > SizeW'(MaxRows)) ? SizeW'(MaxRows) : rows_cfg;
    cols_clamp = (cols_cfg < SizeW'(3)) ? SizeW'(3) :
                 (cols_cfg > SizeW'(MaxColumns)) ? SizeW'(MaxColumns) : cols_cfg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= SizeW'(MaxRows);
      cols_cfg <= SizeW'(MaxColumns);
    end else if (cfg_write) begin
      if (cfg_index == REG_ROWS) rows_cfg <= cfg_data;
      if (cfg_index == REG_COLUMNS) cols_cfg <= cfg_data;
    end
  end

  lanc_nbr u_nbr (
    .row  (row),
    .col  (col),
    .rows (rows),
    .cols (cols),
    .sel  (sel),
    .addr (nbr_addr)
  );

  // Shared update: count up or down for a neighbor, alive bit for the center.
  always_comb begin
    cnt = back_rd[4:1];
    if (sel == 4'd4) begin
      adj_val = adj_up ? (back_rd | CellW'(1)) : (back_rd & CellW'(5'h1E));
    end else begin
      adj_val = {adj_up ? cnt + 1'b1 : cnt - 1'b1, back_rd[0]};
    end
  end

  assign last_col = (SizeW'(col) + 1'b1 == cols);
  assign last_row = (SizeW'(row) + 1'b1 == rows);

  // Memory port control.
  always_comb begin
    front_raddr = center;
    back_raddr  = (state == S_COPY) ? sweep[AddrW-1:0] : nbr_addr;
    front_we    = 1'b0;
    back_we     = 1'b0;
    front_waddr = nbr_addr;
    back_waddr  = nbr_addr;
    front_wdata = adj_val;
    back_wdata  = adj_val;
    unique case (state)
      S_CLEAR: begin
        front_we    = 1'b1;
        back_we     = 1'b1;
        front_waddr = sweep[AddrW-1:0];
        back_waddr  = sweep[AddrW-1:0];
        front_wdata = '0;
        back_wdata  = '0;
      end
      S_ADJ_WR: begin
        back_we  = 1'b1;
        front_we = adj_both;
      end
      S_COPY: begin
        front_we    = (sweep != '0);
        front_waddr = AddrW'(sweep - 1'b1);
        front_wdata = back_rd;
      end
      default: begin
        front_we = 1'b0;
      end
    endcase
  end

  // Cell memories with registered reads.
  always_ff @(posedge clk) begin
    if (front_we) front_mem[front_waddr] <= front_wdata;
    front_rd <= front_mem[front_raddr];
  end

  always_ff @(posedge clk) begin
    if (back_we) back_mem[back_waddr] <= back_wdata;
    back_rd <= back_mem[back_raddr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      sweep     <= '0;
      gen       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (sweep == SweepW'(Cells - 1)) begin
            sweep <= '0;
            state <= S_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            kind <= req.req_type;
            rows <= rows_clamp;
            cols <= cols_clamp;
            // A step walks the field from the first cell.
            row  <= (req.req_type == REQ_STEP) ? '0 : req.cell_row;
            col  <= (req.req_type == REQ_STEP) ? '0 : req.cell_column;
            rsp.generation_count <= gen;
            rsp.cell_alive       <= 1'b0;
            if (req.req_type == REQ_STEP) begin
              state <= S_WALK_RD;
            end else if ((req.req_type == REQ_SET || req.req_type == REQ_READ) &&
                         SizeW'(req.cell_row) < rows_clamp &&
                         SizeW'(req.cell_column) < cols_clamp) begin
              state <= S_CELL_RD;
            end else begin
              rsp_valid <= 1'b1;
            end
          end
        end
        S_CELL_RD: begin
          state <= S_CELL_DEC;
        end
        S_CELL_DEC: begin
          if (kind == REQ_READ || front_rd[0]) begin
            rsp.cell_alive <= front_rd[0];
            rsp_valid      <= 1'b1;
            state          <= S_IDLE;
          end else begin
            adj_up   <= 1'b1;
            adj_both <= 1'b1;
            sel      <= '0;
            state    <= S_ADJ_RD;
          end
        end
        S_WALK_RD: begin
          state <= S_WALK_DEC;
        end
        S_WALK_DEC: begin
          adj_both <= 1'b0;
          sel      <= '0;
          if (front_rd[0] && front_rd[4:1] != 4'd2 && front_rd[4:1] != 4'd3) begin
            adj_up <= 1'b0;
            state  <= S_ADJ_RD;
          end else if (!front_rd[0] && front_rd[4:1] == 4'd3) begin
            adj_up <= 1'b1;
            state  <= S_ADJ_RD;
          end else if (!last_col) begin
            col   <= col + 1'b1;
            state <= S_WALK_RD;
          end else if (!last_row) begin
            col   <= '0;
            row   <= row + 1'b1;
            state <= S_WALK_RD;
          end else begin
            sweep <= '0;
            state <= S_COPY;
          end
        end
        S_ADJ_RD: begin
          state <= S_ADJ_WR;
        end
        S_ADJ_WR: begin
          if (sel != 4'd8) begin
            sel   <= sel + 1'b1;
            state <= S_ADJ_RD;
          end else if (adj_both) begin
            rsp.cell_alive <= 1'b1;
            rsp_valid      <= 1'b1;
            state          <= S_IDLE;
          end else if (!last_col) begin
            col   <= col + 1'b1;
            state <= S_WALK_RD;
          end else if (!last_row) begin
            col   <= '0;
            row   <= row + 1'b1;
            state <= S_WALK_RD;
          end else begin
            sweep <= '0;
            state <= S_COPY;
          end
        end
        S_COPY: begin
          sweep <= sweep + 1'b1;
          if (sweep == SweepW'(Cells)) begin
            gen                  <= gen + 1'b1;
            rsp.generation_count <= gen + 1'b1;
            rsp_valid            <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
